FILE: src/stg_pkg.sv
`timescale 1ns / 1ps
// Package for the sine tone generator: fixed sizes, operation and register codes,
// reciprocal constants for the start arithmetic and the quarter-wave sine function.
// No dependencies.
package stg_pkg;

    // Audio sample rate in Hz and sine table size (entries = 2**SINE_TABLE_BITS).
    localparam int unsigned SAMPLE_RATE     = 44100;
    localparam int unsigned SINE_TABLE_BITS = 10;
    localparam int unsigned TABLE_SIZE      = 1 << SINE_TABLE_BITS;
    localparam int unsigned QTR_SIZE        = TABLE_SIZE / 4;
    localparam int unsigned QTR_BITS        = SINE_TABLE_BITS - 2;
    localparam int unsigned QIDX_BITS       = QTR_BITS + 1;

    // Field widths.
    localparam int unsigned FREQ_BITS  = 15;
    localparam int unsigned DUR_BITS   = 16;
    localparam int unsigned VOL_BITS   = 16;
    localparam int unsigned GAIN_BITS  = 14;
    localparam int unsigned LEN_BITS   = 23;
    localparam int unsigned PHASE_BITS = 32;
    localparam int unsigned MAG_BITS   = 15;

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration port.
    localparam int unsigned APB_AW            = 2;
    localparam logic [APB_AW-1:0] REG_MASTER_VOLUME = 2'd0;
    localparam logic [VOL_BITS-1:0] MASTER_VOL_RESET = 16'hFFFF;

    // Requested volume is clamped to 0.2 of full scale.
    localparam logic [VOL_BITS-1:0] VOL_CLAMP = 16'd13107;

    // Tone length: floor(dur * SAMPLE_RATE / 1000) as one multiply by a rounded-up
    // reciprocal. With dur * SAMPLE_RATE below 2**33 and 1000 below 2**10 a shift of
    // 43 makes the result exact.
    localparam int unsigned LEN_K     = 43;
    localparam int unsigned LEN_MBITS = 51;
    localparam logic [63:0] LEN_RECIP = ((64'd1 << LEN_K) + 64'd999) / 64'd1000;
    localparam logic [LEN_MBITS-1:0] LEN_MULT =
        LEN_MBITS'(LEN_RECIP * 64'(SAMPLE_RATE));

    // Phase step: floor(freq * 2**32 / SAMPLE_RATE). freq * 2**32 is below 2**47 and
    // the rate below 2**17, so a reciprocal rounded up at 2**64 is exact.
    localparam int unsigned STEP_MBITS = 52;
    localparam logic [80:0] STEP_RECIP_W =
        ((81'd1 << 64) + 81'(SAMPLE_RATE) - 81'd1) / 81'(SAMPLE_RATE);
    localparam logic [STEP_MBITS-1:0] STEP_RECIP = STEP_RECIP_W[STEP_MBITS-1:0];

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // 32767 * sin(pi/2 * q / QTR_SIZE), Horner form of the Taylor series in Q30.
    // Evaluated only when the table constants are elaborated.
    function automatic logic [MAG_BITS-1:0] quarter_sine(input logic [QIDX_BITS-1:0] q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s30;
        x  = (64'(q) * HALF_PI_Q30) / 64'(QTR_SIZE);
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
        s30 = (x * t) >> 30;
        s30 = (s30 * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (s30 > 64'd32767) begin
            s30 = 64'd32767;
        end
        return s30[MAG_BITS-1:0];
    endfunction

endpackage

FILE: src/stg_if.sv
`timescale 1ns / 1ps
// Handshake channels of the sine tone generator: command items in, sample items out.
// Depends on stg_pkg for field widths.
interface stg_in_if;
    import stg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [FREQ_BITS-1:0] tone_freq;
    logic [DUR_BITS-1:0]  duration_ms;
    logic [VOL_BITS-1:0]  tone_volume;

    modport source(output valid, output operation, output tone_freq,
                   output duration_ms, output tone_volume, input ready);
    modport sink(input valid, input operation, input tone_freq,
                 input duration_ms, input tone_volume, output ready);
endinterface

interface stg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               sample_valid;
    logic               last_of_tone;

    modport source(output valid, output sample, output sample_valid,
                   output last_of_tone, input ready);
    modport sink(input valid, input sample, input sample_valid,
                 input last_of_tone, output ready);
endinterface

FILE: src/stg_sample_scale.sv
`timescale 1ns / 1ps
// Sine lookup and gain scaling: folds the phase index onto a quarter-wave table,
// scales the magnitude by the tone gain and restores the sign. Depends on stg_pkg.
module stg_sample_scale import stg_pkg::*; (
    input  logic [SINE_TABLE_BITS-1:0] i_phase_idx,
    input  logic [GAIN_BITS-1:0]       i_gain,
    output logic signed [15:0]         o_sample
);

    logic [MAG_BITS-1:0]           w_qtr [QTR_SIZE+1];
    logic [1:0]                    w_region;
    logic [QTR_BITS-1:0]           w_low;
    logic [QIDX_BITS-1:0]          w_q;
    logic [MAG_BITS-1:0]           w_mag;
    logic [MAG_BITS+GAIN_BITS-1:0] w_prod;
    logic [15:0]                   w_scaled;

    // Quarter-wave table, constant after elaboration (one extra entry for the peak).
    for (genvar g = 0; g <= QTR_SIZE; g++) begin : g_qtr
        localparam logic [MAG_BITS-1:0] QV = quarter_sine(QIDX_BITS'(g));
        assign w_qtr[g] = QV;
    end

    assign w_region = i_phase_idx[SINE_TABLE_BITS-1 -: 2];
    assign w_low    = i_phase_idx[QTR_BITS-1:0];
    // Second and fourth quadrants run the table backwards.
    assign w_q      = w_region[0] ? (QIDX_BITS'(QTR_SIZE) - {1'b0, w_low}) : {1'b0, w_low};
    assign w_mag    = w_qtr[w_q];
    assign w_prod   = w_mag * i_gain;
    assign w_scaled = 16'(w_prod[MAG_BITS+GAIN_BITS-1:16]);
    // Lower half of the cycle is negative; scaling the magnitude truncates toward zero.
    assign o_sample = w_region[1] ? -$signed(w_scaled) : $signed(w_scaled);

endmodule

FILE: src/sine_tone_generator_unit.sv
`timescale 1ns / 1ps
// Top level of the sine tone generator: command register, tone state, sample result
// register and APB register port. Depends on stg_pkg, stg_if and stg_sample_scale.
//
//  Channel   Dir  Handshake          Content
//  i_tone    in   valid / ready      operation, tone_freq, duration_ms, tone_volume
//  o_tone    out  valid / ready      sample, sample_valid, last_of_tone
//  APB       in   psel / penable     master_volume at address 0
//
// One item is taken every clock cycle while the command input is not stalled. A tick
// item is held in the command register and is then loaded into the result register, so
// its result reaches the output only after passing through both registers.
// The throughput is set by the single pass from the command register through the sine
// table lookup and the gain multiplier into the result register.
// Reset is synchronous and active low; it leaves the block idle with the master volume
// at full scale. A start item produces no result and passes even while the result
// register is blocked; a tick waits in the command register until the result register
// is free, and while it waits the command input is stalled.
module sine_tone_generator_unit import stg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    stg_in_if.sink            i_tone,
    stg_out_if.source         o_tone,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Command register.
    logic                  r_in_valid;
    logic                  r_in_op;
    logic [FREQ_BITS-1:0]  r_in_freq;
    logic [DUR_BITS-1:0]   r_in_dur;
    logic [VOL_BITS-1:0]   r_in_vol;

    // Tone state.
    logic [VOL_BITS-1:0]   r_master_volume;
    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [PHASE_BITS-1:0] r_phase_step;
    logic [LEN_BITS-1:0]   r_samples_left;
    logic [GAIN_BITS-1:0]  r_tone_gain;
    logic                  r_playing;

    // Result register.
    logic                  r_out_valid;
    logic signed [15:0]    r_out_sample;
    logic                  r_out_sample_valid;
    logic                  r_out_last;

    logic                  w_adv;
    logic                  w_in_acc;
    logic                  w_is_start;
    logic                  w_is_tick;
    logic                  w_cfg_wr;

    logic [GAIN_BITS-1:0]                w_vol_clamped;
    logic [GAIN_BITS+VOL_BITS-1:0]       w_gain_prod;
    logic [DUR_BITS+LEN_MBITS-1:0]       w_len_prod;
    logic [LEN_BITS-1:0]                 w_len;
    logic [FREQ_BITS+STEP_MBITS-1:0]     w_step_prod;
    logic [PHASE_BITS-1:0]               w_step;
    logic                                w_last;
    logic signed [15:0]                  w_sample;

    logic [PHASE_BITS-1:0] n_phase_acc;
    logic [LEN_BITS-1:0]   n_samples_left;

    // ------------------------------------------------------------------
    // Handshake. The command moves on when it is a start, or when the
    // result register is empty or being emptied in this cycle.
    // ------------------------------------------------------------------
    assign w_is_start   = (r_in_op == OP_START);
    assign w_is_tick    = (r_in_op == OP_TICK);
    assign w_adv        = r_in_valid && (w_is_start || !r_out_valid || o_tone.ready);
    assign i_tone.ready = !r_in_valid || w_adv;
    assign w_in_acc     = i_tone.valid && i_tone.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tone.ready) begin
            r_in_valid <= i_tone.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op   <= i_tone.operation;
            r_in_freq <= i_tone.tone_freq;
            r_in_dur  <= i_tone.duration_ms;
            r_in_vol  <= i_tone.tone_volume;
        end
    end

    // ------------------------------------------------------------------
    // Start arithmetic. The gain is the clamped volume scaled by the master
    // volume; length and phase step are exact divisions done as multiplies
    // by constant reciprocals.
    // ------------------------------------------------------------------
    assign w_vol_clamped = (r_in_vol > VOL_CLAMP) ? VOL_CLAMP[GAIN_BITS-1:0]
                                                  : r_in_vol[GAIN_BITS-1:0];
    assign w_gain_prod   = w_vol_clamped * r_master_volume;
    assign w_len_prod    = r_in_dur * LEN_MULT;
    assign w_len         = w_len_prod[LEN_K +: LEN_BITS];
    assign w_step_prod   = r_in_freq * STEP_RECIP;
    // Taking the upper word discards whole turns when the frequency exceeds the rate.
    assign w_step        = w_step_prod[PHASE_BITS +: PHASE_BITS];

    // ------------------------------------------------------------------
    // Tick arithmetic. The sample comes from the phase before it advances.
    // ------------------------------------------------------------------
    stg_sample_scale u_scale (
        .i_phase_idx (r_phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .i_gain      (r_tone_gain),
        .o_sample    (w_sample)
    );

    assign n_phase_acc    = r_phase_acc + r_phase_step;
    assign n_samples_left = r_samples_left - LEN_BITS'(1);
    assign w_last         = (r_samples_left == LEN_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc    <= '0;
            r_phase_step   <= '0;
            r_samples_left <= '0;
            r_tone_gain    <= '0;
            r_playing      <= 1'b0;
        end else if (w_adv) begin
            if (w_is_start) begin
                // A new tone replaces whatever is playing at once.
                r_tone_gain    <= w_gain_prod[VOL_BITS +: GAIN_BITS];
                r_samples_left <= w_len;
                r_phase_step   <= w_step;
                r_phase_acc    <= '0;
                r_playing      <= (w_len != '0);
            end else if (r_playing) begin
                r_phase_acc    <= n_phase_acc;
                r_samples_left <= n_samples_left;
                if (w_last) begin
                    r_playing <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register. Idle ticks give silence with both flags low.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_is_tick) begin
            r_out_valid <= 1'b1;
        end else if (o_tone.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_is_tick) begin
            r_out_sample       <= r_playing ? w_sample : 16'sd0;
            r_out_sample_valid <= r_playing;
            r_out_last         <= r_playing && w_last;
        end
    end

    assign o_tone.valid        = r_out_valid;
    assign o_tone.sample       = r_out_sample;
    assign o_tone.sample_valid = r_out_sample_valid;
    assign o_tone.last_of_tone = r_out_last;

    // ------------------------------------------------------------------
    // Register port. The master volume only takes effect at the next start.
    // ------------------------------------------------------------------
    assign w_cfg_wr = psel && penable && pwrite && (paddr == REG_MASTER_VOLUME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_volume <= MASTER_VOL_RESET;
        end else if (w_cfg_wr) begin
            r_master_volume <= pwdata[VOL_BITS-1:0];
        end
    end

    assign prdata = (paddr == REG_MASTER_VOLUME) ? {16'd0, r_master_volume} : 32'd0;
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The tone is playing exactly while samples remain.
    a_playing_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing == (r_samples_left != '0))
        else $error("playing flag disagrees with the remaining sample count");

    // A start always restarts the phase from zero.
    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_start) |=> (r_phase_acc == '0))
        else $error("phase not cleared by a start");

    // A playing tick advances the phase by exactly one step.
    a_tick_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_tick && r_playing) |=> (r_phase_acc == $past(n_phase_acc)))
        else $error("phase did not advance by the step");

    // The sample flagged as last leaves the block idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_tick && r_playing && w_last) |=> !r_playing)
        else $error("still playing after the last sample");

    // A held command is never overwritten before it has moved on.
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_op)))
        else $error("command register overwritten while held");

endmodule

FILE: tb/sv/stg_tone_checker.sv
`timescale 1ns / 1ps
// Sample checker for the sine tone generator: follows the command, sample and register
// channels, works out every tick's sample and compares it with what the block returns.
// Depends on stg_pkg and on the channel interfaces in stg_if.
module stg_tone_checker import stg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    stg_in_if                 tone_in,
    stg_out_if                tone_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                o_mismatches,
    output int                o_pending
);

    localparam int unsigned     LUT_SIZE    = 1 << SINE_TABLE_BITS;
    localparam int unsigned     LUT_QTR     = LUT_SIZE / 4;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               last_of_tone;
    } tone_sample_t;

    logic signed [15:0]  sine_lut [LUT_SIZE];
    logic [15:0]         master_vol;
    logic [15:0]         gain;
    logic [31:0]         phase;
    logic [31:0]         step;
    logic [LEN_BITS-1:0] remaining;
    logic                playing;
    tone_sample_t        expected_samples [$];

    // Magnitude of 32767*sin(pi/2 * q / LUT_QTR): Taylor series in Horner form, Q30,
    // truncating at every step and rounding once at the final scale.
    function automatic logic [15:0] first_quadrant(input int unsigned q);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned divisor [6];
        divisor = '{156, 110, 72, 42, 20, 6};
        x  = (longint'(q) * Q30_HALF_PI) / LUT_QTR;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int k = 0; k < 6; k++) begin
            t = Q30_ONE - (((x2 * t) >> 30) / divisor[k]);
        end
        s = (x * t) >> 30;
        s = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[15:0];
    endfunction

    initial begin : build_lut
        int unsigned q;
        logic [15:0] mag;
        for (int i = 0; i < LUT_SIZE; i++) begin
            case (i / LUT_QTR)
                0: begin
                    q = i;
                end
                1: begin
                    q = 2 * LUT_QTR - i;
                end
                2: begin
                    q = i - 2 * LUT_QTR;
                end
                default: begin
                    q = 4 * LUT_QTR - i;
                end
            endcase
            mag = first_quadrant(q);
            sine_lut[i] = (i >= 2 * LUT_QTR) ? -$signed(mag) : $signed(mag);
        end
    end

    task automatic start_tone(input logic [FREQ_BITS-1:0] freq,
                              input logic [DUR_BITS-1:0] dur,
                              input logic [VOL_BITS-1:0] vol);
        logic [15:0] clamped;
        clamped   = (vol > VOL_CLAMP) ? VOL_CLAMP : vol;
        gain      = 16'((32'(clamped) * 32'(master_vol)) >> 16);
        remaining = LEN_BITS'((64'(dur) * 64'(SAMPLE_RATE)) / 64'd1000);
        step      = 32'((64'(freq) << 32) / 64'(SAMPLE_RATE));
        phase     = '0;
        playing   = (remaining != '0);
    endtask

    // Sample of one tick; advances the phase and the remaining length of the tone.
    function automatic tone_sample_t synth_tick();
        logic signed [15:0] entry;
        logic [15:0]        mag;
        logic [31:0]        scaled;
        tone_sample_t       r;
        r = '0;
        if (playing) begin
            entry  = sine_lut[phase[31 -: SINE_TABLE_BITS]];
            mag    = (entry < 0) ? 16'(-entry) : 16'(entry);
            scaled = (32'(mag) * 32'(gain)) >> 16;
            r.sample       = (entry < 0) ? -$signed(scaled[15:0]) : $signed(scaled[15:0]);
            r.sample_valid = 1'b1;
            phase     = phase + step;
            remaining = remaining - 1'b1;
            r.last_of_tone = (remaining == '0);
            if (r.last_of_tone) begin
                playing = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        tone_sample_t got;
        tone_sample_t want;
        if (!i_rst_n) begin
            master_vol = MASTER_VOL_RESET;
            gain       = '0;
            phase      = '0;
            step       = '0;
            remaining  = '0;
            playing    = 1'b0;
            expected_samples.delete();
        end else begin
            // Results never leave at the edge where their tick is taken, so compare before predicting.
            if (tone_out.valid && tone_out.ready) begin
                got.sample       = tone_out.sample;
                got.sample_valid = tone_out.sample_valid;
                got.last_of_tone = tone_out.last_of_tone;
                if (expected_samples.size() == 0) begin
                    note_mismatch($sformatf("sample %0d valid %0b last %0b with none expected",
                                            got.sample, got.sample_valid, got.last_of_tone));
                end else begin
                    want = expected_samples.pop_front();
                    if (got !== want) begin
                        note_mismatch($sformatf(
                            "sample expected %0d valid %0b last %0b, got %0d valid %0b last %0b",
                            want.sample, want.sample_valid, want.last_of_tone,
                            got.sample, got.sample_valid, got.last_of_tone));
                    end
                end
            end
            if (tone_in.valid && tone_in.ready) begin
                if (tone_in.operation == OP_START) begin
                    start_tone(tone_in.tone_freq, tone_in.duration_ms, tone_in.tone_volume);
                end else begin
                    expected_samples.push_back(synth_tick());
                end
            end
            if (psel && penable && pready && paddr == REG_MASTER_VOLUME) begin
                if (pwrite) begin
                    master_vol = pwdata[15:0];
                end else if (prdata !== {16'h0, master_vol}) begin
                    note_mismatch($sformatf("master volume read expected %0h, got %0h",
                                            {16'h0, master_vol}, prdata));
                end
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the sine tone generator: clock, reset, command and register stimulus,
// receiver stalls, watchdog and verdict. Depends on stg_pkg, stg_if, the block itself
// and the sample checker in stg_tone_checker.
module tb;
    import stg_pkg::*;

    // Cycles without any accepted item before the run is declared hung. The longest
    // honest quiet stretch is the receiver hold-off plus a sender gap, well below this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the deliberate receiver hold-off that backs the block up to its input.
    localparam int HOLD_CYCLES    = 64;
    // A tick's sample leaves through the command and result registers; a start leaves nothing,
    // so a few spare cycles are allowed before a register write or the verdict.
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;
    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_PHASES     = 5;

    typedef enum {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int       mismatches;
    int       pending_samples;
    int       items_sent;
    int       burst_left;
    int       idle_cycles;
    bit       hold_req;
    int       hold_left;
    int       rx_left;
    int       rx_count;
    t_rx_mode rx_mode;

    stg_in_if  tone_in ();
    stg_out_if tone_out ();

    sine_tone_generator_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tone  (tone_in),
        .o_tone  (tone_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    stg_tone_checker tone_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .tone_in      (tone_in),
        .tone_out     (tone_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending_samples)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Receiver. Its readiness follows a mode that is picked anew at random times: always
    // ready, mostly ready, rarely ready, or a fixed three-in-five pattern. When the
    // stimulus asks for it, it holds off for a long stretch of its own counting, so that
    // the block fills up and has to stall its command input.
    initial begin
        tone_out.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            tone_out.ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            tone_out.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            rx_count++;
            case (rx_mode)
                RX_FREE: begin
                    tone_out.ready <= 1'b1;
                end
                RX_MOSTLY: begin
                    tone_out.ready <= ($urandom_range(0, 3) != 0);
                end
                RX_SPARSE: begin
                    tone_out.ready <= ($urandom_range(0, 9) < 3);
                end
                default: begin
                    tone_out.ready <= ((rx_count % 5) < 3);
                end
            endcase
        end
    end

    // Watchdog: any accepted item, sample or register access counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (tone_in.valid && tone_in.ready) ||
            (tone_out.valid && tone_out.ready) || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sine_tone_generator_unit verification failed");
            $finish;
        end
    end

    // Offers one command item and returns at the falling edge after it was taken. The
    // sender runs in bursts; between bursts it drops valid, and now and then a long burst
    // goes out with no gap at all.
    task automatic send_cmd(input logic op, input logic [FREQ_BITS-1:0] freq,
                            input logic [DUR_BITS-1:0] dur, input logic [VOL_BITS-1:0] vol);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                gap = 0;
                burst_left = $urandom_range(40, 100);
            end else begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
            end
            if (gap != 0) begin
                tone_in.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        tone_in.valid       <= 1'b1;
        tone_in.operation   <= op;
        tone_in.tone_freq   <= freq;
        tone_in.duration_ms <= dur;
        tone_in.tone_volume <= vol;
        @(posedge i_clk);
        while (!tone_in.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_start(input logic [FREQ_BITS-1:0] freq,
                              input logic [DUR_BITS-1:0] dur, input logic [VOL_BITS-1:0] vol);
        send_cmd(OP_START, freq, dur, vol);
    endtask

    // Tick items carry random bits in the fields that only a start reads.
    task automatic send_ticks(input int n);
        repeat (n) begin
            send_cmd(OP_TICK, FREQ_BITS'($urandom), DUR_BITS'($urandom), VOL_BITS'($urandom));
        end
    endtask

    // Mostly audible frequencies, sometimes anything the field can hold.
    function automatic logic [FREQ_BITS-1:0] rand_freq();
        if ($urandom_range(0, 7) == 0) begin
            return FREQ_BITS'($urandom);
        end
        return FREQ_BITS'($urandom_range(20, 20000));
    endfunction

    // One random sequence. Most are short tones played to their end and a little beyond,
    // so the last-sample flag and the idle silence afterwards are seen often; a few are
    // cut short by the next start. The rest are tones of any length that get replaced,
    // zero-length tones, stray ticks and lone starts.
    task automatic play_random_sequence();
        int                  pick;
        int                  len;
        logic [DUR_BITS-1:0] dur;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            dur = DUR_BITS'($urandom_range(1, 3));
            send_start(rand_freq(), dur, VOL_BITS'($urandom));
            len = (int'(dur) * int'(SAMPLE_RATE)) / 1000;
            if ($urandom_range(0, 6) == 0) begin
                send_ticks($urandom_range(1, len - 1));
            end else begin
                send_ticks(len + $urandom_range(0, 3));
            end
        end else if (pick < 78) begin
            send_start(rand_freq(), DUR_BITS'($urandom), VOL_BITS'($urandom));
            send_ticks($urandom_range(1, 16));
        end else if (pick < 88) begin
            send_start(rand_freq(), '0, VOL_BITS'($urandom));
            send_ticks($urandom_range(1, 3));
        end else if (pick < 94) begin
            send_ticks($urandom_range(1, 4));
        end else begin
            send_start(FREQ_BITS'($urandom), DUR_BITS'($urandom), VOL_BITS'($urandom));
        end
    endtask

    // One APB transfer: a setup phase, then the access phase held until pready, then a spare
    // idle gap so that back-to-back transfers never touch a signal twice in one step.
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stops offering items and waits until every expected sample has come back, plus a
    // few cycles for a start that may still be on its way through the command register.
    task automatic settle();
        tone_in.valid <= 1'b0;
        while (pending_samples != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [15:0] vol_setting [4];
        logic [15:0] vol;
        int          phase_first;

        vol_setting = '{16'd0, 16'hFFFF, 16'd1, 16'h8000};

        i_rst_n             = 1'b0;
        tone_in.valid       = 1'b0;
        tone_in.operation   = OP_TICK;
        tone_in.tone_freq   = '0;
        tone_in.duration_ms = '0;
        tone_in.tone_volume = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = REG_MASTER_VOLUME;
        pwdata              = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset master volume. A tick straight after reset must be
        // silent, as must one after a zero-length tone.
        send_ticks(1);
        send_start('0, '0, '0);
        send_ticks(1);
        // All fields at their maximum: the volume is clamped and the tone is very long.
        send_start('1, '1, '1);
        send_ticks(3);
        // Nyquist frequency at exactly the clamp level, started over the running tone.
        send_start(FREQ_BITS'(22050), '1, VOL_CLAMP);
        send_ticks(3);
        // Lowest non-zero frequency, one step above the clamp level.
        send_start(FREQ_BITS'(1), '1, VOL_CLAMP + 16'd1);
        send_ticks(2);
        // A zero-length start stops the running tone at once.
        send_start(FREQ_BITS'(440), '0, '1);
        send_ticks(1);
        // Zero volume gives flagged but silent samples.
        send_start(FREQ_BITS'(1000), DUR_BITS'(1), '0);
        send_ticks(2);
        // A quarter of the sample rate with alternating bit patterns; this tone is left
        // running into the first register write below.
        send_start(FREQ_BITS'(11025), 16'h7FFF, 16'h2AAA);
        send_ticks(3);

        // Random phases, each at its own master volume: both extremes first, then small,
        // middle and a random value. The write happens with the channels idle but a tone
        // still playing, whose gain must not follow the new master volume. Each phase
        // opens with a long receiver hold-off while the sender keeps offering items.
        for (int p = 0; p < NUM_PHASES; p++) begin
            vol = (p < 4) ? vol_setting[p] : 16'($urandom);
            settle();
            apb_access(1'b1, REG_MASTER_VOLUME, {16'h0, vol});
            apb_access(1'b0, REG_MASTER_VOLUME, '0);
            send_ticks($urandom_range(2, 5));
            phase_first = items_sent;
            hold_req    = 1'b1;
            while (items_sent - phase_first < PHASE_ITEMS) begin
                play_random_sequence();
            end
            send_start(rand_freq(), DUR_BITS'($urandom_range(100, 65535)),
                       VOL_BITS'($urandom));
            send_ticks($urandom_range(2, 6));
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("sine_tone_generator_unit verification clean");
        end else begin
            $display("sine_tone_generator_unit verification failed");
        end
        $finish;
    end

endmodule
